// ===== src/masg_pkg.sv =====
// shared constants, codes and types for the multi-axis step generator
`default_nettype none
package masg_pkg;

  localparam int AXES       = 4;
  localparam int STEP_W     = 24;
  localparam int RATE_W     = 20;
  localparam int ACC_W      = 24;
  localparam int TICK_W     = 24;
  localparam int MINP_W     = 16;
  localparam int PW_W       = 8;
  localparam int SHIFT_W    = 4;
  localparam int LIM_W      = 3;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;
  localparam int PERIOD_W   = 24;
  localparam int MUL_W      = 24;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int DIV_NUM_W  = TICK_W + 1;
  localparam int DIV_CNT_W  = 5;
  localparam int SQ_IN_W    = 50;
  localparam int SQ_ROOT_W  = SQ_IN_W / 2;
  localparam int SQ_REM_W   = SQ_ROOT_W + 3;
  localparam int SQ_CNT_W   = 5;

  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIV_NUM_W);
  localparam logic [SQ_CNT_W-1:0]  SQ_STEPS  = SQ_CNT_W'(SQ_ROOT_W);
  localparam logic [PERIOD_W-1:0]  PERIOD_MAX = {PERIOD_W{1'b1}};

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ESTOP = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BUSY  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_WIDTH = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROFILE_EN  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_EN   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_SH   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_MIN  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_INVERT  = 4'd7;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_PDIV_GO, S_PDIV_WAIT, S_PLOAD, S_MUL_V0, S_MUL_A,
    S_SQA_GO, S_SQA_WAIT, S_MUL_D, S_SQD_GO, S_SQD_WAIT, S_CLAMP,
    S_TDIV_GO, S_TDIV_WAIT, S_TLOAD, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_REJECT, OP_QUIET, OP_START, OP_TICK, OP_DIV_GO, OP_PLOAD,
    OP_MUL_V0, OP_MUL_A, OP_SQA_GO, OP_MUL_D, OP_SQD_GO, OP_CLAMP, OP_TLOAD,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic   take;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic item_valid;
    logic func;
    logic busy;
    logic major_zero;
    logic tick_update;
    logic profile_en;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== src/masg_ifs.sv =====
// request channels of the step generator: items in, results out, config writes
`default_nettype none
interface masg_item_if import masg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic signed [STEP_W-1:0] steps_x;
  logic signed [STEP_W-1:0] steps_y;
  logic signed [STEP_W-1:0] steps_z;
  logic signed [STEP_W-1:0] steps_phi;
  logic [RATE_W-1:0]        start_rate;
  logic [RATE_W-1:0]        max_rate;
  logic [ACC_W-1:0]         accel_rate;
  logic [LIM_W-1:0]         stop_mask;
  logic                     estop;
  logic [LIM_W-1:0]         limits_latched;

  modport source (output valid, func, steps_x, steps_y, steps_z, steps_phi, start_rate,
                  max_rate, accel_rate, stop_mask, estop, limits_latched, input ready);
  modport sink (input valid, func, steps_x, steps_y, steps_z, steps_phi, start_rate,
                max_rate, accel_rate, stop_mask, estop, limits_latched, output ready);
endinterface

interface masg_result_if import masg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              moving;
  logic              finished;
  logic              limit_stop;
  logic [LIM_W-1:0]  limits_hit;
  logic [AXES-1:0]   step_lines;
  logic [AXES-1:0]   dir_lines;
  logic [AXES-1:0]   stepped;

  modport source (output valid, status, moving, finished, limit_stop, limits_hit,
                  step_lines, dir_lines, stepped, input ready);
  modport sink (input valid, status, moving, finished, limit_stop, limits_hit,
                step_lines, dir_lines, stepped, output ready);
endinterface

interface masg_cfg_if import masg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/masg_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module masg_div import masg_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [DIV_NUM_W-1:0] num,
  input  wire logic [RATE_W-1:0]    den,
  output logic [DIV_NUM_W-1:0]      quot,
  output logic                      done
);

  logic [RATE_W-1:0]    rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic [RATE_W:0]      trial;
  logic [RATE_W:0]      diff;

  always_comb begin
    trial = {rem, quot[DIV_NUM_W-1]};
    diff  = trial - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt  <= DIV_STEPS;
      rem  <= '0;
      quot <= num;
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
      if (trial >= {1'b0, den}) begin
        rem  <= diff[RATE_W-1:0];
        quot <= {quot[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem  <= trial[RATE_W-1:0];
        quot <= {quot[DIV_NUM_W-2:0], 1'b0};
      end
    end
  end

  assign done = (cnt == '0);

endmodule
`default_nettype wire

// ===== src/masg_isqrt.sv =====
// iterative integer square root, one root bit per cycle
`default_nettype none
module masg_isqrt import masg_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [SQ_IN_W-1:0] radicand,
  output logic [SQ_ROOT_W-1:0]    root,
  output logic                    done
);

  logic [SQ_IN_W-1:0]  rad;
  logic [SQ_REM_W-1:0] rem;
  logic [SQ_CNT_W-1:0] cnt;
  logic [SQ_REM_W-1:0] rem_sh;
  logic [SQ_REM_W-1:0] trial;

  always_comb begin
    rem_sh = {rem[SQ_REM_W-3:0], rad[SQ_IN_W-1 -: 2]};
    trial  = {1'b0, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt  <= SQ_STEPS;
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
      rad <= {rad[SQ_IN_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[SQ_ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[SQ_ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done = (cnt == '0);

endmodule
`default_nettype wire

// ===== src/masg_ctrl.sv =====
// sequencer that steps the datapath through one item at a time
`default_nettype none
module masg_ctrl import masg_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.take   = 1'b0;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (stat.item_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (stat.func) begin
          if (stat.busy) begin
            cmd.op     = OP_REJECT;
            state_next = S_DONE;
          end else begin
            cmd.op     = OP_START;
            state_next = stat.major_zero ? S_DONE : S_PDIV_GO;
          end
        end else if (!stat.busy) begin
          cmd.op     = OP_QUIET;
          state_next = S_DONE;
        end else begin
          cmd.op = OP_TICK;
          if (!stat.tick_update) state_next = S_DONE;
          else if (stat.profile_en) state_next = S_MUL_V0;
          else state_next = S_CLAMP;
        end
      end
      S_PDIV_GO: begin
        cmd.op     = OP_DIV_GO;
        state_next = S_PDIV_WAIT;
      end
      S_PDIV_WAIT: begin
        if (stat.div_done) state_next = S_PLOAD;
      end
      S_PLOAD: begin
        cmd.op     = OP_PLOAD;
        state_next = S_DONE;
      end
      S_MUL_V0: begin
        cmd.op     = OP_MUL_V0;
        state_next = S_MUL_A;
      end
      S_MUL_A: begin
        cmd.op     = OP_MUL_A;
        state_next = S_SQA_GO;
      end
      S_SQA_GO: begin
        cmd.op     = OP_SQA_GO;
        state_next = S_SQA_WAIT;
      end
      S_SQA_WAIT: begin
        if (stat.sqrt_done) state_next = S_MUL_D;
      end
      S_MUL_D: begin
        cmd.op     = OP_MUL_D;
        state_next = S_SQD_GO;
      end
      S_SQD_GO: begin
        cmd.op     = OP_SQD_GO;
        state_next = S_SQD_WAIT;
      end
      S_SQD_WAIT: begin
        if (stat.sqrt_done) state_next = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.op     = OP_CLAMP;
        state_next = S_TDIV_GO;
      end
      S_TDIV_GO: begin
        cmd.op     = OP_DIV_GO;
        state_next = S_TDIV_WAIT;
      end
      S_TDIV_WAIT: begin
        if (stat.div_done) state_next = S_TLOAD;
      end
      S_TLOAD: begin
        cmd.op     = OP_TLOAD;
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold until the result register is free
        if (stat.out_free) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/masg_dp.sv =====
// move state, dda slice logic, speed profile arithmetic and result register
`default_nettype none
module masg_dp import masg_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire dp_cmd_t  cmd,
  output dp_stat_t      stat,
  masg_item_if.sink     item,
  masg_result_if.source result,
  masg_cfg_if.sink      cfg
);

  // configuration
  logic [TICK_W-1:0]  tick_rate;
  logic [MINP_W-1:0]  min_period;
  logic [PW_W-1:0]    pulse_width;
  logic               profile_en;
  logic               smooth_en;
  logic [SHIFT_W-1:0] smooth_shift;
  logic [PW_W-1:0]    smooth_min_step;
  logic [AXES-1:0]    dir_invert;

  // latched item
  logic                          it_func;
  logic [AXES-1:0][STEP_W-1:0]   it_steps;
  logic [RATE_W-1:0]             it_start;
  logic [RATE_W-1:0]             it_max;
  logic [ACC_W-1:0]              it_acc;
  logic [LIM_W-1:0]              it_mask;
  logic                          it_estop;
  logic [LIM_W-1:0]              it_limits;

  // move state
  logic                        busy, complete, limit_abort, rejected;
  logic [STAT_W-1:0]           last_status;
  logic [LIM_W-1:0]            hit_mask, abort_mask;
  logic [STEP_W-1:0]           slice_count, major_steps, major_remaining;
  logic [PERIOD_W-1:0]         period_now;
  logic [RATE_W-1:0]           speed_start, speed_max, speed_cur;
  logic [ACC_W-1:0]            accel_value;
  logic [AXES-1:0][STEP_W-1:0] axis_steps, axis_accum;
  logic [AXES-1:0][PW_W-1:0]   pulse_count;
  logic [AXES-1:0]             axis_dir, step_level, stepped;

  // profile arithmetic
  logic [PROD_W-1:0]    prod, v0sq;
  logic [SQ_ROOT_W-1:0] va;
  logic [MUL_W-1:0]     mul_a, mul_b;

  // start decode
  logic [AXES-1:0][STEP_W-1:0] st_mag;
  logic [AXES-1:0]             st_neg;
  logic [STEP_W-1:0]           st_major;
  logic [RATE_W-1:0]           st_vmax, st_vstart;
  logic [ACC_W-1:0]            st_acc;

  // tick decode
  logic [AXES-1:0][PW_W-1:0]   pc_dec;
  logic [AXES-1:0]             lvl_dec, fire;
  logic [AXES-1:0][STEP_W:0]   acc_sum, acc_sub;
  logic [AXES-1:0][STEP_W-1:0] acc_next;
  logic [STEP_W-1:0]           sc_inc, rem_dec;
  logic [LIM_W-1:0]            hit;
  logic                        slice_hit;

  // speed, period and smoothing
  logic [SQ_ROOT_W-1:0]        vmin, sq_root;
  logic [RATE_W-1:0]           v_cap, clamp_speed;
  logic [DIV_NUM_W-1:0]        div_num, div_q;
  logic [PERIOD_W-1:0]         pfor;
  logic signed [PERIOD_W+1:0]  err, shd, delta, np;
  logic [PERIOD_W-1:0]         smooth_period;
  logic [SQ_IN_W-1:0]          radicand;
  logic                        div_done, sqrt_done, div_start, sqrt_start;

  assign cfg.ready  = 1'b1;
  assign item.ready = cmd.take;

  always_comb begin
    st_major = '0;
    for (int i = 0; i < AXES; i++) begin
      st_neg[i] = it_steps[i][STEP_W-1];
      st_mag[i] = st_neg[i] ? (~it_steps[i] + 1'b1) : it_steps[i];
      if (st_mag[i] > st_major) st_major = st_mag[i];
    end
    st_vmax   = (it_max == '0) ? RATE_W'(1) : it_max;
    st_vstart = (it_start == '0) ? RATE_W'(1) : it_start;
    if (st_vstart > st_vmax) st_vstart = st_vmax;
    st_acc    = (it_acc == '0) ? ACC_W'(1) : it_acc;
  end

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      pc_dec[i]  = (pulse_count[i] != '0) ? pulse_count[i] - 1'b1 : '0;
      lvl_dec[i] = (pulse_count[i] == PW_W'(1)) ? 1'b0 : step_level[i];
      acc_sum[i] = {1'b0, axis_accum[i]} + {1'b0, axis_steps[i]};
      acc_sub[i] = acc_sum[i] - {1'b0, major_steps};
      fire[i]    = (axis_steps[i] != '0) && (acc_sum[i] >= {1'b0, major_steps});
      if (axis_steps[i] == '0) acc_next[i] = axis_accum[i];
      else if (fire[i]) acc_next[i] = acc_sub[i][STEP_W-1:0];
      else acc_next[i] = acc_sum[i][STEP_W-1:0];
    end
    sc_inc    = slice_count + 1'b1;
    slice_hit = !(sc_inc < period_now);
    rem_dec   = major_remaining - 1'b1;
    hit       = abort_mask & it_limits;
  end

  always_comb begin
    vmin        = (va < sq_root) ? va : sq_root;
    v_cap       = (vmin > {{(SQ_ROOT_W-RATE_W){1'b0}}, speed_max}) ? speed_max
                                                                  : vmin[RATE_W-1:0];
    clamp_speed = (v_cap < speed_start) ? speed_start : v_cap;
    div_num     = {1'b0, tick_rate} + {{(DIV_NUM_W-RATE_W){1'b0}}, speed_cur} - 1'b1;
    pfor        = (div_q < {{(DIV_NUM_W-MINP_W){1'b0}}, min_period})
                  ? {{(PERIOD_W-MINP_W){1'b0}}, min_period} : div_q[PERIOD_W-1:0];
    // negative errors shift toward minus infinity
    err   = $signed({2'b00, pfor}) - $signed({2'b00, period_now});
    shd   = err >>> smooth_shift;
    delta = (shd == '0 && err > 0)
            ? $signed({{(PERIOD_W+2-PW_W){1'b0}}, smooth_min_step}) : shd;
    np    = $signed({2'b00, period_now}) + delta;
    if (np < $signed({{(PERIOD_W+2-MINP_W){1'b0}}, min_period}))
      smooth_period = {{(PERIOD_W-MINP_W){1'b0}}, min_period};
    else if (np > $signed({2'b00, PERIOD_MAX}))
      smooth_period = PERIOD_MAX;
    else
      smooth_period = np[PERIOD_W-1:0];
    radicand = {2'b00, v0sq} + {1'b0, prod, 1'b0};
  end

  always_comb begin
    mul_a = accel_value;
    mul_b = major_remaining;
    case (cmd.op)
      OP_MUL_V0: begin
        mul_a = {{(MUL_W-RATE_W){1'b0}}, speed_start};
        mul_b = {{(MUL_W-RATE_W){1'b0}}, speed_start};
      end
      OP_MUL_A: mul_b = major_steps - major_remaining;
      default: ;
    endcase
  end

  assign div_start  = (cmd.op == OP_DIV_GO);
  assign sqrt_start = (cmd.op == OP_SQA_GO) || (cmd.op == OP_SQD_GO);

  masg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (speed_cur),
    .quot  (div_q),
    .done  (div_done)
  );

  masg_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (radicand),
    .root     (sq_root),
    .done     (sqrt_done)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate       <= TICK_W'(100000);
      min_period      <= MINP_W'(2);
      pulse_width     <= PW_W'(2);
      profile_en      <= 1'b1;
      smooth_en       <= 1'b0;
      smooth_shift    <= SHIFT_W'(2);
      smooth_min_step <= PW_W'(1);
      dir_invert      <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_TICK_RATE:   tick_rate       <= cfg.data[TICK_W-1:0];
        CFG_MIN_PERIOD:  min_period      <= cfg.data[MINP_W-1:0];
        CFG_PULSE_WIDTH: pulse_width     <= cfg.data[PW_W-1:0];
        CFG_PROFILE_EN:  profile_en      <= cfg.data[0];
        CFG_SMOOTH_EN:   smooth_en       <= cfg.data[0];
        CFG_SMOOTH_SH:   smooth_shift    <= cfg.data[SHIFT_W-1:0];
        CFG_SMOOTH_MIN:  smooth_min_step <= cfg.data[PW_W-1:0];
        CFG_DIR_INVERT:  dir_invert      <= cfg.data[AXES-1:0];
        default: ;
      endcase
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (item.valid && cmd.take) begin
      it_func     <= item.func;
      it_steps[0] <= item.steps_x;
      it_steps[1] <= item.steps_y;
      it_steps[2] <= item.steps_z;
      it_steps[3] <= item.steps_phi;
      it_start    <= item.start_rate;
      it_max      <= item.max_rate;
      it_acc      <= item.accel_rate;
      it_mask     <= item.stop_mask;
      it_estop    <= item.estop;
      it_limits   <= item.limits_latched;
    end
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.op == OP_MUL_V0 || cmd.op == OP_MUL_A || cmd.op == OP_MUL_D)
      prod <= mul_a * mul_b;
    if (cmd.op == OP_MUL_A) v0sq <= prod;
    if (cmd.op == OP_MUL_D) va <= sq_root;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy            <= 1'b0;
      complete        <= 1'b0;
      limit_abort     <= 1'b0;
      rejected        <= 1'b0;
      last_status     <= STAT_OK;
      hit_mask        <= '0;
      abort_mask      <= '0;
      slice_count     <= '0;
      period_now      <= '0;
      major_steps     <= '0;
      major_remaining <= '0;
      speed_start     <= '0;
      speed_max       <= '0;
      speed_cur       <= '0;
      accel_value     <= '0;
      axis_steps      <= '0;
      axis_accum      <= '0;
      pulse_count     <= '0;
      axis_dir        <= '0;
      step_level      <= '0;
      stepped         <= '0;
    end else begin
      case (cmd.op)
        OP_REJECT: begin
          rejected <= 1'b1;
          stepped  <= '0;
        end
        OP_QUIET: begin
          rejected <= 1'b0;
          stepped  <= '0;
        end
        OP_START: begin
          rejected    <= 1'b0;
          stepped     <= '0;
          last_status <= STAT_OK;
          limit_abort <= 1'b0;
          hit_mask    <= '0;
          abort_mask  <= it_mask;
          axis_dir    <= ~st_neg;
          axis_steps  <= st_mag;
          if (st_major == '0) begin
            complete <= 1'b1;
          end else begin
            complete        <= 1'b0;
            axis_accum      <= '0;
            pulse_count     <= '0;
            step_level      <= '0;
            major_steps     <= st_major;
            major_remaining <= st_major;
            speed_start     <= st_vstart;
            speed_max       <= st_vmax;
            speed_cur       <= st_vstart;
            accel_value     <= st_acc;
            slice_count     <= '0;
          end
        end
        OP_PLOAD: begin
          period_now <= pfor;
          busy       <= 1'b1;
        end
        OP_TICK: begin
          rejected <= 1'b0;
          stepped  <= '0;
          if (it_estop) begin
            busy        <= 1'b0;
            complete    <= 1'b1;
            last_status <= STAT_ESTOP;
            pulse_count <= '0;
            step_level  <= '0;
          end else if (hit != '0) begin
            hit_mask    <= hit;
            limit_abort <= 1'b1;
            busy        <= 1'b0;
            complete    <= 1'b1;
            last_status <= STAT_OK;
            pulse_count <= '0;
            step_level  <= '0;
          end else if (!slice_hit) begin
            slice_count <= sc_inc;
            pulse_count <= pc_dec;
            step_level  <= lvl_dec;
          end else begin
            slice_count     <= '0;
            axis_accum      <= acc_next;
            stepped         <= fire;
            major_remaining <= rem_dec;
            if (rem_dec == '0) begin
              // last step: reported, but lines already dropped
              busy        <= 1'b0;
              complete    <= 1'b1;
              last_status <= STAT_OK;
              pulse_count <= '0;
              step_level  <= '0;
            end else begin
              for (int i = 0; i < AXES; i++) begin
                pulse_count[i] <= fire[i] ? pulse_width : pc_dec[i];
                step_level[i]  <= fire[i] | lvl_dec[i];
              end
            end
          end
        end
        OP_CLAMP: speed_cur <= profile_en ? clamp_speed : speed_start;
        OP_TLOAD: period_now <= smooth_en ? smooth_period : pfor;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      result.status     <= rejected ? STAT_BUSY : last_status;
      result.moving     <= busy;
      result.finished   <= complete;
      result.limit_stop <= limit_abort;
      result.limits_hit <= hit_mask;
      result.step_lines <= step_level;
      result.dir_lines  <= axis_dir ^ dir_invert;
      result.stepped    <= stepped;
    end
  end

  always_comb begin
    stat.item_valid  = item.valid;
    stat.func        = it_func;
    stat.busy        = busy;
    stat.major_zero  = (st_major == '0);
    stat.tick_update = !it_estop && (hit == '0) && slice_hit && (rem_dec != '0);
    stat.profile_en  = profile_en;
    stat.div_done    = div_done;
    stat.sqrt_done   = sqrt_done;
    stat.out_free    = !result.valid || result.ready;
  end

  a_busy_remaining: assert property (@(posedge clk) disable iff (rst)
    busy |-> major_remaining != '0)
    else $error("moving with no major steps left");

  a_busy_not_done: assert property (@(posedge clk) disable iff (rst)
    busy |-> !complete)
    else $error("move both running and finished");

  a_estop_stop: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_TICK && it_estop) |=>
      (!busy && last_status == STAT_ESTOP && step_level == '0))
    else $error("emergency stop did not end the move");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_OUT) |=> result.valid)
    else $error("result load lost");

endmodule
`default_nettype wire

// ===== src/multi_axis_step_generator_unit.sv =====
// four-axis trapezoidal step generator: one result per request, one request at a time
// the 25-step square root (run twice) and the 25-step period divider set the slow path;
//   a new request is taken while a result waits
// reset: synchronous, clears move state and loads config defaults; no clearing pass
`default_nettype none
module multi_axis_step_generator_unit import masg_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  masg_item_if.sink     item,
  masg_result_if.source result,
  masg_cfg_if.sink      cfg
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  masg_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  masg_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .stat   (stat),
    .item   (item),
    .result (result),
    .cfg    (cfg)
  );

endmodule
`default_nettype wire

// ===== tb/masg_checker.sv =====
// scoreboard for the step generator: tracks move state and compares every result
`timescale 1ns / 100ps
`default_nettype none
module masg_checker import masg_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  masg_item_if      item,
  masg_result_if    result,
  masg_cfg_if       cfg,
  output int        errors,
  output int        pending
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              moving;
    logic              finished;
    logic              limit_stop;
    logic [LIM_W-1:0]  limits_hit;
    logic [AXES-1:0]   step_lines;
    logic [AXES-1:0]   dir_lines;
    logic [AXES-1:0]   stepped;
  } motion_out_t;

  motion_out_t expected_q[$];

  // register copies
  bit [TICK_W-1:0]   tick_rate;
  bit [MINP_W-1:0]   min_period;
  bit [PW_W-1:0]     pulse_width;
  bit                profile_en, smooth_en;
  bit [SHIFT_W-1:0]  smooth_sh;
  bit [7:0]          smooth_min;
  bit [AXES-1:0]     dir_inv;

  // move state
  bit                busy, complete, limit_abort;
  bit [STAT_W-1:0]   last_status;
  bit [LIM_W-1:0]    hit_mask, abort_mask;
  bit [31:0]         slice_count, period_now, major_steps, major_rem;
  bit [31:0]         v_start, v_max, accel;
  bit [31:0]         axis_cnt[AXES], axis_acc[AXES], pulse_ticks[AXES];
  bit [AXES-1:0]     axis_fwd, step_hi;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned rem, res, b;
    rem = x; res = 0; b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = res + (b << 1);
      end
      res = res >> 1;
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic bit [31:0] ticks_per_step(bit [31:0] speed);
    longint unsigned s, p;
    s = (speed < 1) ? 1 : speed;
    p = (longint'(tick_rate) + s - 1) / s;
    if (p < min_period) p = min_period;
    return p[31:0];
  endfunction

  function automatic bit [31:0] profile_speed(bit [31:0] done, bit [31:0] left);
    longint unsigned v0sq, va, vd, v;
    if (!profile_en) return v_start;
    v0sq = longint'(v_start) * v_start;
    va = int_sqrt(v0sq + 2 * longint'(accel) * done);
    vd = int_sqrt(v0sq + 2 * longint'(accel) * left);
    v = (va < vd) ? va : vd;
    if (v_max < v) v = v_max;
    if (v < v_start) v = v_start;
    return v[31:0];
  endfunction

  task automatic stop_move(bit [STAT_W-1:0] code);
    busy = 0;
    complete = 1;
    last_status = code;
    for (int i = 0; i < AXES; i++) begin
      pulse_ticks[i] = 0;
      step_hi[i] = 0;
    end
  endtask

  task automatic load_move();
    bit [STEP_W-1:0] raw[AXES];
    bit [31:0] major, vs, vm, ac;
    raw[0] = item.steps_x; raw[1] = item.steps_y;
    raw[2] = item.steps_z; raw[3] = item.steps_phi;
    major = 0;
    complete = 0;
    last_status = STAT_OK;
    limit_abort = 0;
    hit_mask = 0;
    abort_mask = item.stop_mask;
    for (int i = 0; i < AXES; i++) begin
      axis_fwd[i] = !raw[i][STEP_W-1];
      axis_cnt[i] = raw[i][STEP_W-1] ? ((32'd1 << STEP_W) - raw[i]) : raw[i];
      if (axis_cnt[i] > major) major = axis_cnt[i];
    end
    if (major == 0) begin
      busy = 0;
      complete = 1;
      return;
    end
    for (int i = 0; i < AXES; i++) begin
      axis_acc[i] = 0;
      pulse_ticks[i] = 0;
      step_hi[i] = 0;
    end
    major_steps = major;
    major_rem = major;
    vs = item.start_rate;
    vm = item.max_rate;
    ac = item.accel_rate;
    if (vm < 1) vm = 1;
    if (vs < 1) vs = 1;
    if (vs > vm) vs = vm;
    if (ac < 1) ac = 1;
    v_start = vs;
    v_max = vm;
    accel = ac;
    slice_count = 0;
    period_now = ticks_per_step(vs);
    busy = 1;
  endtask

  task automatic advance_tick(output bit [AXES-1:0] fired);
    bit [LIM_W-1:0] hit;
    bit [31:0] target;
    longint err, delta, np;
    longint unsigned mag;
    fired = 0;
    if (!busy) return;
    for (int i = 0; i < AXES; i++) begin
      if (pulse_ticks[i] != 0) begin
        pulse_ticks[i]--;
        if (pulse_ticks[i] == 0) step_hi[i] = 0;
      end
    end
    if (item.estop) begin
      stop_move(STAT_ESTOP);
      return;
    end
    hit = abort_mask & item.limits_latched;
    if (hit != 0) begin
      hit_mask = hit;
      limit_abort = 1;
      stop_move(STAT_OK);
      return;
    end
    slice_count = (slice_count + 1) & 32'hFFFFFF;
    if (slice_count < period_now) return;
    slice_count = 0;
    for (int i = 0; i < AXES; i++) begin
      if (axis_cnt[i] != 0) begin
        axis_acc[i] += axis_cnt[i];
        if (axis_acc[i] >= major_steps) begin
          axis_acc[i] -= major_steps;
          step_hi[i] = 1;
          pulse_ticks[i] = pulse_width;
          fired[i] = 1;
        end
      end
    end
    major_rem = (major_rem - 1) & 32'hFFFFFF;
    if (major_rem == 0) begin
      stop_move(STAT_OK);
      return;
    end
    target = ticks_per_step(profile_speed(major_steps - major_rem, major_rem));
    if (smooth_en) begin
      err = longint'(target) - longint'(period_now);
      if (err >= 0) begin
        delta = err >> smooth_sh;
      end else begin
        mag = -err;
        delta = -longint'((mag + (64'd1 << smooth_sh) - 1) >> smooth_sh);
      end
      if (delta == 0 && err != 0) delta = (err > 0) ? longint'(smooth_min) : -longint'(smooth_min);
      np = longint'(period_now) + delta;
      if (np < longint'(min_period)) np = min_period;
      if (np > longint'(PERIOD_MAX)) np = PERIOD_MAX;
      period_now = np[31:0];
    end else begin
      period_now = target;
    end
  endtask

  task automatic predict_request();
    motion_out_t e;
    bit [AXES-1:0] fired;
    fired = 0;
    if (item.func) begin
      if (busy) begin
        e.status = STAT_BUSY;
      end else begin
        load_move();
        e.status = last_status;
      end
    end else begin
      advance_tick(fired);
      e.status = last_status;
    end
    e.moving = busy;
    e.finished = complete;
    e.limit_stop = limit_abort;
    e.limits_hit = hit_mask;
    e.step_lines = step_hi;
    e.dir_lines = axis_fwd ^ dir_inv;
    e.stepped = fired;
    expected_q.push_back(e);
  endtask

  task automatic compare_result();
    motion_out_t got, e;
    got = '{result.status, result.moving, result.finished, result.limit_stop,
            result.limits_hit, result.step_lines, result.dir_lines, result.stepped};
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("%0t: unexpected result %p", $time, got);
      return;
    end
    e = expected_q.pop_front();
    if (got !== e) begin
      errors++;
      if (errors <= 10) $display("%0t: result mismatch\n  expected %p\n  actual   %p", $time, e, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      tick_rate = TICK_W'(100000); min_period = MINP_W'(2); pulse_width = PW_W'(2);
      profile_en = 1; smooth_en = 0; smooth_sh = SHIFT_W'(2); smooth_min = 8'd1;
      dir_inv = '0;
      busy = 0; complete = 0; limit_abort = 0;
      last_status = STAT_OK; hit_mask = '0; abort_mask = '0;
      slice_count = 0; period_now = 0; major_steps = 0; major_rem = 0;
      v_start = 0; v_max = 0; accel = 0;
      axis_fwd = '0; step_hi = '0;
      for (int i = 0; i < AXES; i++) begin
        axis_cnt[i] = 0; axis_acc[i] = 0; pulse_ticks[i] = 0;
      end
      expected_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_TICK_RATE:   tick_rate = cfg.data[TICK_W-1:0];
          CFG_MIN_PERIOD:  min_period = cfg.data[MINP_W-1:0];
          CFG_PULSE_WIDTH: pulse_width = cfg.data[PW_W-1:0];
          CFG_PROFILE_EN:  profile_en = cfg.data[0];
          CFG_SMOOTH_EN:   smooth_en = cfg.data[0];
          CFG_SMOOTH_SH:   smooth_sh = cfg.data[SHIFT_W-1:0];
          CFG_SMOOTH_MIN:  smooth_min = cfg.data[7:0];
          CFG_DIR_INVERT:  dir_inv = cfg.data[AXES-1:0];
          default: ;
        endcase
      end
      // result first: it belongs to an earlier request
      if (result.valid && result.ready) compare_result();
      if (item.valid && item.ready) predict_request();
    end
    pending = expected_q.size();
  end

  initial begin
    errors = 0;
    pending = 0;
  end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// top of the step generator testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import masg_pkg::*;

  typedef struct {
    bit                func;
    bit [STEP_W-1:0]   sx, sy, sz, sp;
    bit [RATE_W-1:0]   v0, vmax;
    bit [ACC_W-1:0]    acc;
    bit [LIM_W-1:0]    mask;
    bit                estop;
    bit [LIM_W-1:0]    lim;
  } motion_req_t;

  logic clk, rst;
  int   errors, pending;
  int   send_idle, recv_idle;
  int   sent;
  bit   hold_results;

  masg_item_if   item ();
  masg_result_if result ();
  masg_cfg_if    cfg ();

  multi_axis_step_generator_unit u_dut (
    .clk(clk), .rst(rst), .item(item), .result(result), .cfg(cfg)
  );

  masg_checker u_checker (
    .clk(clk), .rst(rst), .item(item), .result(result), .cfg(cfg),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // result side: random stalls, or a long hold-off when asked
  initial begin
    result.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        result.ready = 0;
        repeat (400) @(negedge clk);
        hold_results = 0;
      end else begin
        result.ready = ($urandom_range(99) >= recv_idle);
      end
    end
  end

  function automatic motion_req_t noise_req();
    motion_req_t r;
    r.func = 0;
    r.sx = STEP_W'($urandom); r.sy = STEP_W'($urandom);
    r.sz = STEP_W'($urandom); r.sp = STEP_W'($urandom);
    r.v0 = RATE_W'($urandom); r.vmax = RATE_W'($urandom); r.acc = ACC_W'($urandom);
    r.mask = LIM_W'($urandom); r.estop = 0; r.lim = '0;
    return r;
  endfunction

  task automatic push_request(motion_req_t r);
    while ($urandom_range(99) < send_idle) @(negedge clk);
    item.func = r.func;
    item.steps_x = r.sx; item.steps_y = r.sy; item.steps_z = r.sz; item.steps_phi = r.sp;
    item.start_rate = r.v0; item.max_rate = r.vmax; item.accel_rate = r.acc;
    item.stop_mask = r.mask; item.estop = r.estop; item.limits_latched = r.lim;
    item.valid = 1;
    // ready only moves at a rising edge, so its level now holds for the coming edge
    while (!item.ready) @(negedge clk);
    @(negedge clk);
    item.valid = 0;
    sent++;
  endtask

  task automatic send_tick(bit stop, bit [LIM_W-1:0] lim);
    motion_req_t r;
    r = noise_req();
    r.estop = stop;
    r.lim = lim;
    push_request(r);
  endtask

  task automatic send_start(int x, int y, int z, int p, int v0, int vmax, int acc,
                            bit [LIM_W-1:0] mask);
    motion_req_t r;
    r = noise_req();
    r.func = 1;
    r.sx = STEP_W'(x); r.sy = STEP_W'(y); r.sz = STEP_W'(z); r.sp = STEP_W'(p);
    r.v0 = RATE_W'(v0); r.vmax = RATE_W'(vmax); r.acc = ACC_W'(acc); r.mask = mask;
    r.estop = 1'($urandom);
    r.lim = LIM_W'($urandom);
    push_request(r);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg.index = idx;
    cfg.data = CFG_DATA_W'(value);
    cfg.valid = 1;
    while (!cfg.ready) @(negedge clk);
    @(negedge clk);
    cfg.valid = 0;
  endtask

  task automatic drain();
    wait (pending == 0);
    repeat (120) @(negedge clk);
  endtask

  task automatic set_regs(int tr, int mp, int pw, int pe, int se, int sh, int sm, int di);
    drain();
    write_reg(CFG_TICK_RATE, tr);
    write_reg(CFG_MIN_PERIOD, mp);
    write_reg(CFG_PULSE_WIDTH, pw);
    write_reg(CFG_PROFILE_EN, pe);
    write_reg(CFG_SMOOTH_EN, se);
    write_reg(CFG_SMOOTH_SH, sh);
    write_reg(CFG_SMOOTH_MIN, sm);
    write_reg(CFG_DIR_INVERT, di);
  endtask

  function automatic int rand_count();
    int m;
    case ($urandom_range(19))
      0: return 0;
      1, 2: return int'($urandom_range(24'hFFFFFF)) - (1 << 23);
      default: begin
        m = $urandom_range(24);
        return $urandom_range(1) ? -m : m;
      end
    endcase
  endfunction

  // one move: start, a burst of ticks with rare faults and rare extra starts, then an estop to clear it
  task automatic random_move(int tr);
    int n, v0, vm;
    v0 = $urandom_range(3) == 0 ? $urandom : $urandom_range(tr + 1);
    vm = $urandom_range(3) == 0 ? $urandom : $urandom_range(4 * tr + 4);
    send_start(rand_count(), rand_count(), rand_count(), rand_count(), v0, vm,
               $urandom_range(3) == 0 ? $urandom : $urandom_range(200), LIM_W'($urandom));
    n = $urandom_range(20, 140);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(60) == 0)
        send_start(rand_count(), 1, 2, 3, 5, 5, 5, 0);
      else
        send_tick($urandom_range(150) == 0,
                  $urandom_range(40) == 0 ? 3'($urandom) : 3'd0);
    end
    send_tick(1, 0);
  endtask

  task automatic random_phase(int target, int tr);
    while (sent < target) random_move(tr);
  endtask

  initial begin
    rst = 1;
    sent = 0;
    hold_results = 0;
    send_idle = 22;
    recv_idle = 86;
    item.valid = 0; item.func = 0;
    item.steps_x = 0; item.steps_y = 0; item.steps_z = 0; item.steps_phi = 0;
    item.start_rate = 0; item.max_rate = 0; item.accel_rate = 0;
    item.stop_mask = 0; item.estop = 0; item.limits_latched = 0;
    cfg.valid = 0; cfg.index = 0; cfg.data = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed part
    set_regs(8, 1, 3, 1, 0, 2, 1, 4'b0101);
    send_tick(1, 3'b111);                                    // tick while idle
    send_start(0, 0, 0, 0, 10, 10, 10, 3'b111);              // all-zero move
    send_start(8388607, -8388607, -8388608, 0, 0, 0, 0, 3'b111);
    repeat (4) send_tick(0, 0);
    send_start(1, 1, 1, 1, 1, 1, 1, 0);                      // rejected while busy
    send_tick(0, 3'b111);                                    // limit abort
    send_start(3, -2, 1, -3, 1048575, 5, 16777215, 3'b000);  // start rate cut to max
    repeat (10) send_tick(0, 3'b111);                        // unmasked switches
    send_tick(1, 0);                                         // estop abort
    send_start(2, 0, 0, 0, 8, 8, 1, 3'b010);
    repeat (6) send_tick(0, 3'b101);                         // runs to its last step

    // long result hold-off while requests keep coming
    send_start(20, -7, 3, 0, 2, 16, 3, 0);
    hold_results = 1;
    repeat (12) send_tick(0, 0);
    wait (pending == 0);
    @(negedge clk);
    send_tick(1, 0);

    set_regs(40, 1, 1, 1, 1, 0, 0, 4'hF);
    random_phase(350, 40);
    set_regs(100, 3, 255, 1, 1, 15, 255, 0);
    random_phase(650, 100);
    send_idle = 86;
    recv_idle = 22;
    set_regs(12, 0, 2, 0, 0, 2, 1, 4'b1010);
    random_phase(950, 12);
    set_regs(0, 1, 4, 1, 1, 3, 7, 4'b0011);
    random_phase(1100, 1);
    send_idle = 0;
    recv_idle = 0;
    set_regs(16777215, 65535, 5, 1, 1, 1, 2, 4'b1100);
    random_phase(1250, 1);
    set_regs(60, 2, 2, 1, 1, 2, 1, 4'b0110);
    random_phase(1850, 60);

    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
